@@ rtl/rrp_pkg.sv @@
// Shared types and constants of the rectangle raster painter.
package rrp_pkg;

   localparam int EDGE_W = 28;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] KIND_FILLED  = 8'd82;
   localparam logic [7:0] KIND_OUTLINE = 8'd114;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [1:0] STATUS_BAD_KIND = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd3;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BG     = 2'd2;

   typedef enum logic [2:0] {
      JOB_CLEAR,
      JOB_FILL,
      JOB_OUTLINE,
      JOB_READ,
      JOB_DONE
   } job_cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_READ
   } back_state_type;

   typedef struct packed {
      job_cmd_type             cmd;
      logic [1:0]              status;
      logic [7:0]              paint_char;
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] left_in;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] right_in;
      logic signed [EDGE_W-1:0] top;
      logic signed [EDGE_W-1:0] top_in;
      logic signed [EDGE_W-1:0] bottom;
      logic signed [EDGE_W-1:0] bottom_in;
      logic [7:0]              read_x;
      logic [7:0]              read_y;
   } job_type;

endpackage

@@ rtl/rrp_front.sv @@
// Front end: accept request items, check them and turn them into jobs.
module rrp_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8,
   localparam int COL_W = $clog2(MAX_WIDTH + 1),
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [119:0]      req_tdata,
   input  logic [9:0]        req_tuser,
   input  logic [COL_W-1:0]  width_eff,
   input  logic [ROW_W-1:0]  height_eff,
   input  logic              q_full,
   output logic              q_push,
   output rrp_pkg::job_type  q_wdata
);

   localparam int EW = rrp_pkg::EDGE_W;
   localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

   logic [1:0]  op;
   logic [7:0]  kind;
   logic [23:0] left_raw;
   logic [23:0] top_raw;
   logic [23:0] span_x_raw;
   logic [23:0] span_y_raw;
   logic signed [EW-1:0] left_x;
   logic signed [EW-1:0] top_x;
   logic signed [EW-1:0] span_x;
   logic signed [EW-1:0] span_y;
   logic signed [EW-1:0] right_x;
   logic signed [EW-1:0] bottom_x;
   logic        size_bad;
   logic        kind_ok;
   logic        read_out;

   assign op         = req_tuser[1:0];
   assign kind       = req_tuser[9:2];
   assign left_raw   = req_tdata[23:0];
   assign top_raw    = req_tdata[47:24];
   assign span_x_raw = req_tdata[71:48];
   assign span_y_raw = req_tdata[95:72];

   assign left_x   = $signed({{(EW-24){left_raw[23]}}, left_raw});
   assign top_x    = $signed({{(EW-24){top_raw[23]}}, top_raw});
   assign span_x   = $signed({{(EW-24){span_x_raw[23]}}, span_x_raw});
   assign span_y   = $signed({{(EW-24){span_y_raw[23]}}, span_y_raw});
   assign right_x  = left_x + span_x;
   assign bottom_x = top_x + span_y;

   assign size_bad = (span_x <= $signed(EW'(0))) || (span_y <= $signed(EW'(0)));
   assign kind_ok  = (kind == rrp_pkg::KIND_FILLED) || (kind == rrp_pkg::KIND_OUTLINE);
   assign read_out = ({3'b000, req_tdata[111:104]} >= 11'(width_eff)) ||
                     ({3'b000, req_tdata[119:112]} >= 11'(height_eff));

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_wdata            = '0;
      q_wdata.paint_char = req_tdata[103:96];
      q_wdata.read_x     = req_tdata[111:104];
      q_wdata.read_y     = req_tdata[119:112];
      q_wdata.left       = left_x;
      q_wdata.left_in    = left_x + $signed(ONE);
      q_wdata.right      = right_x;
      q_wdata.right_in   = right_x - $signed(ONE);
      q_wdata.top        = top_x;
      q_wdata.top_in     = top_x + $signed(ONE);
      q_wdata.bottom     = bottom_x;
      q_wdata.bottom_in  = bottom_x - $signed(ONE);
      q_wdata.status     = rrp_pkg::STATUS_OK;
      q_wdata.cmd        = rrp_pkg::JOB_DONE;
      unique case (op)
         rrp_pkg::OP_CLEAR: begin
            q_wdata.cmd = rrp_pkg::JOB_CLEAR;
         end
         rrp_pkg::OP_DRAW: begin
            priority if (size_bad) begin
               q_wdata.status = rrp_pkg::STATUS_BAD_SIZE;
            end else if (!kind_ok) begin
               q_wdata.status = rrp_pkg::STATUS_BAD_KIND;
            end else if (kind == rrp_pkg::KIND_FILLED) begin
               q_wdata.cmd = rrp_pkg::JOB_FILL;
            end else begin
               q_wdata.cmd = rrp_pkg::JOB_OUTLINE;
            end
         end
         rrp_pkg::OP_READ: begin
            if (read_out) begin
               q_wdata.status = rrp_pkg::STATUS_OUTSIDE;
            end else begin
               q_wdata.cmd = rrp_pkg::JOB_READ;
            end
         end
         default: begin
            q_wdata.cmd = rrp_pkg::JOB_DONE;
         end
      endcase
   end

endmodule

@@ rtl/rrp_queue.sv @@
// Two-entry job queue between the front end and the painter.
module rrp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rrp_pkg::job_type wdata,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output rrp_pkg::job_type head
);

   rrp_pkg::job_type slots_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/rrp_back.sv @@
// Back end: scan the canvas memory for clear and draw jobs, serve reads, hold the result.
module rrp_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8,
   localparam int COL_W = $clog2(MAX_WIDTH + 1),
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [COL_W-1:0]  width_eff,
   input  logic [ROW_W-1:0]  height_eff,
   input  logic [7:0]        background_char,
   input  logic              q_empty,
   input  rrp_pkg::job_type  q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [1:0]        rsp_tuser
);

   localparam int EW    = rrp_pkg::EDGE_W;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] canvas_mem [DEPTH];

   rrp_pkg::back_state_type state_ff;
   rrp_pkg::back_state_type state_in;
   rrp_pkg::job_type        job_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [AW-1:0]           base_ff;
   logic [7:0]              rd_data_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [7:0]              rsp_char_ff;

   logic                    load_job;
   logic                    mem_we;
   logic                    rd_en;
   logic                    load_rsp;
   logic [1:0]              rsp_status_in;
   logic [7:0]              rsp_char_in;
   logic [7:0]              wr_char;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic                    last_col;
   logic                    last_row;
   logic                    paint;
   logic                    in_rect;
   logic                    near_edge;
   logic signed [EW-1:0]    px;
   logic signed [EW-1:0]    py;

   assign px = $signed(EW'(col_ff) << FRAC_BITS);
   assign py = $signed(EW'(row_ff) << FRAC_BITS);

   assign in_rect = (job_ff.left <= px) && (px <= job_ff.right) &&
                    (job_ff.top <= py) && (py <= job_ff.bottom);
   assign near_edge = (px < job_ff.left_in) || (px > job_ff.right_in) ||
                      (py < job_ff.top_in) || (py > job_ff.bottom_in);

   assign last_col = (col_ff == width_eff - COL_W'(1));
   assign last_row = (row_ff == height_eff - ROW_W'(1));
   assign wr_addr  = base_ff + AW'(col_ff);
   assign rd_addr  = AW'(AW'(q_head.read_y) * AW'(MAX_WIDTH)) + AW'(q_head.read_x);

   always_comb begin
      unique case (job_ff.cmd)
         rrp_pkg::JOB_CLEAR:   paint = 1'b1;
         rrp_pkg::JOB_FILL:    paint = in_rect;
         rrp_pkg::JOB_OUTLINE: paint = in_rect && near_edge;
         default:              paint = 1'b0;
      endcase
      wr_char = (job_ff.cmd == rrp_pkg::JOB_CLEAR) ? background_char : job_ff.paint_char;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrp_pkg::BK_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               unique case (q_head.cmd)
                  rrp_pkg::JOB_CLEAR, rrp_pkg::JOB_FILL, rrp_pkg::JOB_OUTLINE:
                     state_in = rrp_pkg::BK_SCAN;
                  rrp_pkg::JOB_READ:
                     state_in = rrp_pkg::BK_READ;
                  default:
                     state_in = rrp_pkg::BK_IDLE;
               endcase
            end
         end
         rrp_pkg::BK_SCAN: begin
            if (last_col && last_row) begin
               state_in = rrp_pkg::BK_IDLE;
            end
         end
         rrp_pkg::BK_READ: begin
            state_in = rrp_pkg::BK_IDLE;
         end
         default: begin
            state_in = rrp_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      load_job      = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      load_rsp      = 1'b0;
      rsp_status_in = rrp_pkg::STATUS_OK;
      rsp_char_in   = 8'd0;
      unique case (state_ff)
         rrp_pkg::BK_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               load_job = 1'b1;
               unique case (q_head.cmd)
                  rrp_pkg::JOB_READ: begin
                     rd_en = 1'b1;
                  end
                  rrp_pkg::JOB_DONE: begin
                     load_rsp      = 1'b1;
                     rsp_status_in = q_head.status;
                  end
                  default: begin
                     load_rsp = 1'b0;
                  end
               endcase
            end
         end
         rrp_pkg::BK_SCAN: begin
            mem_we = paint;
            if (last_col && last_row) begin
               load_rsp = 1'b1;
            end
         end
         rrp_pkg::BK_READ: begin
            load_rsp    = 1'b1;
            rsp_char_in = rd_data_ff;
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrp_pkg::BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_job || (state_ff == rrp_pkg::BK_SCAN && last_col && last_row)) begin
            col_ff  <= '0;
            row_ff  <= '0;
            base_ff <= '0;
         end else if (state_ff == rrp_pkg::BK_SCAN) begin
            if (last_col) begin
               col_ff  <= '0;
               row_ff  <= row_ff + ROW_W'(1);
               base_ff <= base_ff + AW'(MAX_WIDTH);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff <= q_head;
      end
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_char_ff   <= rsp_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[wr_addr] <= wr_char;
      end
      if (rd_en) begin
         rd_data_ff <= canvas_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ rtl/rectangle_raster_painter.sv @@
// Rectangle raster painter top level: configuration registers, front end, job queue, back end.
// A clear or a valid draw item walks every pixel of the canvas in use, one pixel per cycle
// through the single write port of the canvas memory; a read goes through the registered
// memory read, and a rejected or ignored item is answered straight from the idle state.
// The canvas memory has no reset and holds garbage until the first clear item. Up to two
// items queue in front of the painter, and the result register lets the next item start
// once the previous result is taken.
module rectangle_raster_painter #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left[23:0], top[47:24], span_x[71:48], span_y[95:72], paint_char[103:96],
   // read_x[111:104], read_y[119:112]
   input  logic [119:0] req_tdata,
   // op[1:0], shape_kind[9:2]
   input  logic [9:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pixel_char[7:0]
   output logic [7:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   logic [8:0]       width_ff;
   logic [8:0]       height_ff;
   logic [7:0]       bg_ff;
   logic [COL_W-1:0] width_eff;
   logic [ROW_W-1:0] height_eff;

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   rrp_pkg::job_type q_wdata;
   rrp_pkg::job_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         bg_ff     <= 8'd32;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rrp_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            rrp_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            rrp_pkg::CSR_BG:     bg_ff     <= csr_wdata[7:0];
            default:             bg_ff     <= bg_ff;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff == 9'd0) begin
         width_eff = COL_W'(1);
      end else if ({2'b00, width_ff} > 11'(MAX_WIDTH)) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = COL_W'(width_ff);
      end
      priority if (height_ff == 9'd0) begin
         height_eff = ROW_W'(1);
      end else if ({2'b00, height_ff} > 11'(MAX_HEIGHT)) begin
         height_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff = ROW_W'(height_ff);
      end
   end

   rrp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   rrp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (q_head)
   );

   rrp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .width_eff       (width_eff),
      .height_eff      (height_eff),
      .background_char (bg_ff),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

endmodule

@@ rtl/rrp_checker.sv @@
// Port-level checker for the rectangle raster painter, bound to the top level.
module rrp_bus_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       in_fire;
   logic       out_fire;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (in_fire && !out_fire) begin
         pending_in = pending_ff + 3'd1;
      end else if (out_fire && !in_fire) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("result without an accepted item");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd3 |-> !req_tready)
      else $error("item taken with queue and painter full");

   a_char_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rrp_pkg::STATUS_OK |-> rsp_tdata == 8'd0)
      else $error("pixel char on error result");

endmodule

bind rectangle_raster_painter rrp_bus_checker u_rrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
